// ===== src/slu_pkg.sv =====
// Shared types and codes for the string literal unescaper.
package slu_pkg;

  // Input kinds (s_tuser)
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Result status codes (m_tuser)
  localparam logic [2:0] ST_BYTE      = 3'd0;
  localparam logic [2:0] ST_CLOSED    = 3'd1;
  localparam logic [2:0] ST_ENDED_OK  = 3'd2;
  localparam logic [2:0] ST_ILLEGAL   = 3'd3;
  localparam logic [2:0] ST_NEWLINE   = 3'd4;
  localparam logic [2:0] ST_UNEXP_END = 3'd5;

  // Configuration register indexes
  localparam logic CFG_QUOTE_BYTE     = 1'b0;
  localparam logic CFG_CLOSE_REQUIRED = 1'b1;

  // Decoder modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_BODY = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_OCT  = 2'd3;

  typedef struct packed {
    logic [7:0] quote_byte;
    logic       close_required;
  } cfg_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_byte;
    logic       last;
  } result_t;

  // Outcome of one input item: up to two results plus the next state
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
    logic [1:0] mode_next;
    logic [7:0] octal_next;
  } step_t;

endpackage

// ===== src/slu_step.sv =====
// Per-item decode logic: maps the current state and one input item to results.
module slu_step (
  input  logic [1:0]    mode,
  input  logic [7:0]    octal_value,
  input  logic [1:0]    kind,
  input  logic [7:0]    in_byte,
  input  slu_pkg::cfg_t cfg,
  output slu_pkg::step_t step
);
  import slu_pkg::*;

  typedef struct packed {
    logic       emit;
    result_t    res;
    logic [1:0] mode;
  } body_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_NL    = 8'h0A;

  body_t      bt;
  logic       is_oct;
  logic       esc_ok;
  logic [7:0] esc_byte;
  logic       end_bad;

  assign is_oct  = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);
  assign end_bad = cfg.close_required;

  // Ordinary body byte; quote check wins over backslash
  always_comb begin
    bt = '0;
    bt.mode = MODE_BODY;
    priority if (in_byte == cfg.quote_byte) begin
      bt.emit = 1'b1;
      bt.res  = '{status: ST_CLOSED, out_byte: 8'h00, last: 1'b1};
      bt.mode = MODE_IDLE;
    end else if (in_byte == CH_BSL) begin
      bt.mode = MODE_ESC;
    end else if (in_byte == CH_NL && cfg.close_required) begin
      bt.emit = 1'b1;
      bt.res  = '{status: ST_NEWLINE, out_byte: 8'h00, last: 1'b1};
      bt.mode = MODE_IDLE;
    end else begin
      bt.emit = 1'b1;
      bt.res  = '{status: ST_BYTE, out_byte: in_byte, last: 1'b0};
    end
  end

  // Single-character escapes
  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = in_byte;
    unique case (in_byte)
      8'h6E:   esc_byte = 8'h0A;  // n
      8'h72:   esc_byte = 8'h0D;  // r
      8'h62:   esc_byte = 8'h08;  // b
      8'h74:   esc_byte = 8'h09;  // t
      8'h66:   esc_byte = 8'h0C;  // f
      8'h27, 8'h22, 8'h5C, 8'h2F: esc_byte = in_byte;
      default: esc_ok = 1'b0;
    endcase
  end

  // State update and result selection
  always_comb begin
    step = '0;
    step.mode_next  = mode;
    step.octal_next = octal_value;
    priority if (kind == KIND_START) begin
      step.mode_next  = MODE_BODY;
      step.octal_next = 8'h00;
    end else if (kind == KIND_BYTE && mode != MODE_IDLE) begin
      unique case (mode)
        MODE_BODY: begin
          step.count     = {1'b0, bt.emit};
          step.res0      = bt.res;
          step.mode_next = bt.mode;
        end
        MODE_ESC: begin
          priority if (is_oct) begin
            step.octal_next = in_byte - CH_ZERO;
            step.mode_next  = MODE_OCT;
          end else if (in_byte == CH_NL) begin
            // continuation: newline is dropped
            step.mode_next = MODE_BODY;
          end else if (esc_ok) begin
            step.count     = 2'd1;
            step.res0      = '{status: ST_BYTE, out_byte: esc_byte, last: 1'b0};
            step.mode_next = MODE_BODY;
          end else begin
            step.count     = 2'd1;
            step.res0      = '{status: ST_ILLEGAL, out_byte: 8'h00, last: 1'b1};
            step.mode_next = MODE_IDLE;
          end
        end
        MODE_OCT: begin
          priority if (in_byte == CH_UNDER) begin
            step.count = 2'd0;
          end else if (is_oct) begin
            step.octal_next = {octal_value[4:0], in_byte[2:0]};
          end else begin
            // flush the octal byte, then decode this byte as body
            step.count      = bt.emit ? 2'd2 : 2'd1;
            step.res0       = '{status: ST_BYTE, out_byte: octal_value, last: 1'b0};
            step.res1       = bt.res;
            step.octal_next = 8'h00;
            step.mode_next  = bt.mode;
          end
        end
        default: step.mode_next = MODE_IDLE;
      endcase
    end else if (kind == KIND_END && mode != MODE_IDLE) begin
      step.mode_next = MODE_IDLE;
      unique case (mode)
        MODE_BODY: begin
          step.count = 2'd1;
          step.res0  = '{status: end_bad ? ST_UNEXP_END : ST_ENDED_OK,
                         out_byte: 8'h00, last: 1'b1};
        end
        MODE_ESC: begin
          step.count = 2'd1;
          step.res0  = '{status: ST_UNEXP_END, out_byte: 8'h00, last: 1'b1};
        end
        MODE_OCT: begin
          step.count      = 2'd2;
          step.res0       = '{status: ST_BYTE, out_byte: octal_value, last: 1'b0};
          step.res1       = '{status: end_bad ? ST_UNEXP_END : ST_ENDED_OK,
                              out_byte: 8'h00, last: 1'b1};
          step.octal_next = 8'h00;
        end
        default: step.count = 2'd0;
      endcase
    end
  end

endmodule

// ===== src/slu_out_fifo.sv =====
// Four-entry result queue taking up to two results per cycle.
module slu_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_count,
  input  slu_pkg::result_t push0,
  input  slu_pkg::result_t push1,
  output logic             room2,
  output logic             head_valid,
  output slu_pkg::result_t head,
  input  logic             pop
);
  import slu_pkg::*;

  result_t    mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       do_pop;

  assign head_valid = (count != 3'd0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;
  assign room2      = (count <= 3'd2);

  // Storage writes
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      rd_ptr <= rd_ptr + {1'b0, do_pop};
      count  <= count + {1'b0, push_count} - {2'b00, do_pop};
    end
  end

endmodule

// ===== src/string_literal_unescaper_core.sv =====
// Top level of the string literal unescaper.
//
//  channel | handshake                  | payload
//  --------+----------------------------+----------------------------------
//  in      | s_tvalid / s_tready        | s_tdata: in_byte; s_tuser: kind
//  out     | m_tvalid / m_tready        | m_tdata: out_byte; m_tuser: status;
//          |                            | m_tlast: last
//  cfg     | cfg_we                     | cfg_index, cfg_data
//
// One input item per cycle while s_tready is high. Each accepted item is
// decoded in the cycle of its transfer and its zero to two results go into
// a four-entry result queue; s_tready drops only when the queue has room
// for fewer than two results; the two results of one item leave in order.
// Reset (synchronous, rst high) empties the queue, puts the decoder in idle
// and loads quote_byte 34 and close_required 1.
module string_literal_unescaper_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic [1:0] s_tuser,   // [1:0] kind
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [2:0] m_tuser,   // [2:0] status
  output logic       m_tlast,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import slu_pkg::*;

  cfg_t       cfg;
  logic [1:0] mode;
  logic [7:0] octal_value;
  step_t      step;
  logic       in_xfer;
  logic       room2;
  result_t    head;

  assign s_tready = room2;
  assign in_xfer  = s_tvalid && s_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quote_byte     <= 8'd34;
      cfg.close_required <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUOTE_BYTE:     cfg.quote_byte     <= cfg_data;
        CFG_CLOSE_REQUIRED: cfg.close_required <= cfg_data[0];
        default:            cfg.quote_byte     <= cfg.quote_byte;
      endcase
    end
  end

  slu_step u_step (
    .mode        (mode),
    .octal_value (octal_value),
    .kind        (s_tuser),
    .in_byte     (s_tdata),
    .cfg         (cfg),
    .step        (step)
  );

  // Decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      octal_value <= 8'h00;
    end else if (in_xfer) begin
      mode        <= step.mode_next;
      octal_value <= step.octal_next;
    end
  end

  slu_out_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (in_xfer ? step.count : 2'd0),
    .push0      (step.res0),
    .push1      (step.res1),
    .room2      (room2),
    .head_valid (m_tvalid),
    .head       (head),
    .pop        (m_tready)
  );

  assign m_tdata = head.out_byte;
  assign m_tuser = head.status;
  assign m_tlast = head.last;

endmodule
